[src/mcs_pkg.sv]
// Shared types and constants of the magnetometer calibration sequencer.
`default_nettype none

package mcs_pkg;

    // Word layouts on the stream ports.
    localparam int IN_FIELDS_W  = 50;
    localparam int IN_DATA_W    = 56;
    localparam int IN_USER_W    = 1;
    localparam int OUT_FIELDS_W = 105;
    localparam int OUT_DATA_W   = 112;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam int NUM_AXES     = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 3;

    // Fixed-point settings.
    localparam logic [15:0] UNITY_GAIN     = 16'd16384;
    localparam logic [1:0]  SELFTEST_PAUSE = 2'd2;
    localparam int          GAIN_FRAC_BITS = 14;
    localparam logic [15:0] GAIN_SAT       = 16'hFFFF;

    // Serial divider: one quotient bit per cycle over the 32-bit numerator.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Input word kinds.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Bus actions requested from the sensor interface.
    localparam logic [2:0] ACT_NONE           = 3'd0;
    localparam logic [2:0] ACT_READ           = 3'd1;
    localparam logic [2:0] ACT_WRITE_IDLE     = 3'd2;
    localparam logic [2:0] ACT_WRITE_SELFTEST = 3'd3;
    localparam logic [2:0] ACT_WRITE_CONT     = 3'd4;
    localparam logic [2:0] ACT_BUS_RESET      = 3'd5;

    // Sequence steps with a meaning of their own.
    localparam logic [2:0] STEP_START    = 3'd0;
    localparam logic [2:0] STEP_IDLE_WR  = 3'd2;
    localparam logic [2:0] STEP_SELFTEST = 3'd4;
    localparam logic [2:0] STEP_CALIB    = 3'd5;
    localparam logic [2:0] STEP_CONT_WR  = 3'd6;
    localparam logic [2:0] STEP_DATA     = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FIELD_MAX = 3'd0;
    localparam logic [2:0] CFG_FIELD_MIN = 3'd1;
    localparam logic [2:0] CFG_GAIN_NUM  = 3'd2;
    localparam logic [2:0] CFG_OFFSET_X  = 3'd3;
    localparam logic [2:0] CFG_OFFSET_Y  = 3'd4;
    localparam logic [2:0] CFG_OFFSET_Z  = 3'd5;
    localparam logic [2:0] CFG_AXIS_MAP  = 3'd6;
    localparam logic [2:0] CFG_SIGN_MAP  = 3'd7;

    // Axis selector code that maps a body axis to no raw word.
    localparam logic [1:0] AXIS_SEL_NONE = 2'd3;

    // Operands of the shared scaling unit for one body axis.
    typedef struct packed {
        logic signed [15:0] raw;
        logic [15:0]        gain;
        logic               negate;
        logic signed [15:0] offset;
    } scale_op_t;

    // Result of the serial divider.
    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } div_res_t;

endpackage

`default_nettype wire

[src/mcs_div.sv]
// Serial restoring divider computing a saturated 16-bit gain quotient.
`default_nettype none

module mcs_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      num,
    input  wire logic [14:0]      den,
    output mcs_pkg::div_res_t     res
);
    import mcs_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [31:0]          quo_reg;
    logic [14:0]          rem_reg;
    logic [14:0]          den_reg;
    logic [15:0]          trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end
        else
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            // The quotient bits shift in where the numerator bits leave.
            quo_reg <= {quo_reg[30:0], fits};
            rem_reg <= fits ? 15'(trial - {1'b0, den_reg}) : trial[14:0];
        end
    end

    assign res.done = done_reg;
    assign res.quot = (quo_reg[31:16] != '0) ? GAIN_SAT : quo_reg[15:0];

endmodule

`default_nettype wire

[src/mcs_scale.sv]
// Shared scaling unit: gain multiply, then sign, offset and range check.
`default_nettype none

module mcs_scale (
    input  wire logic                clk,
    input  wire mcs_pkg::scale_op_t  op,
    input  wire logic [14:0]         field_max,
    output logic signed [15:0]       field,
    output logic                     in_range
);
    import mcs_pkg::*;

    logic signed [32:0] prod_reg;
    logic               negate_reg;
    logic signed [15:0] offset_reg;
    logic signed [15:0] field_reg;
    logic               in_range_reg;

    logic [15:0]        scaled;
    logic [15:0]        signed_val;
    logic signed [15:0] half_offset;
    logic signed [15:0] field_next;
    logic [16:0]        field_ext;
    logic [16:0]        mag;

    // First stage: the product of raw word and gain.
    always_ff @(posedge clk)
    begin
        prod_reg   <= op.raw * $signed({1'b0, op.gain});
        negate_reg <= op.negate;
        offset_reg <= op.offset;
    end

    // Second stage works modulo 2^16, which matches the final wrap.
    always_comb
    begin
        scaled      = prod_reg[GAIN_FRAC_BITS +: 16];
        signed_val  = negate_reg ? 16'(-scaled) : scaled;
        half_offset = offset_reg >>> 1;
        field_next  = $signed(16'(signed_val - half_offset));
        field_ext   = {field_next[15], field_next};
        mag         = field_next[15] ? 17'(-field_ext) : field_ext;
    end

    always_ff @(posedge clk)
    begin
        field_reg    <= field_next;
        in_range_reg <= (mag < {2'b00, field_max});
    end

    assign field    = field_reg;
    assign in_range = in_range_reg;

endmodule

`default_nettype wire

[src/magnetometer_calib_sequencer.sv]
// Top level: start-up sequencer, calibration and field compensation of a magnetometer.
// A tick or an ignored read completion goes through S_DECODE to S_OUT; a data read
// makes three passes through the two-stage scaling unit; a calibration read runs
// three 32-step divisions. The block takes one word at a time: the serial divider
// and the scaling unit serve one axis at a time, and the input is not ready until
// the result is queued.
// Reset (rst_n, asynchronous, active low) sets step 0, no pause, unity gains, zero fields.
`default_nettype none

module magnetometer_calib_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Slave side; tdata from bit 0: bus_ok, transfer_ok, raw_word0, raw_word1, raw_word2,
    // zero fill.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [mcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser from bit 0: cmd.
    input  wire logic [mcs_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // Master side; tdata from bit 0: action, step, field_x, field_y, field_z, field_valid,
    // reading_rejected, calib_failed, gain_x_out, gain_y_out, gain_z_out, zero fill.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [mcs_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [mcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mcs_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_MUL_A    = 3'd4;
    localparam logic [2:0] S_MUL_B    = 3'd5;
    localparam logic [2:0] S_MUL_C    = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

    // Configuration registers.
    logic [14:0]        field_max_reg;
    logic [14:0]        field_min_reg;
    logic [31:0]        gain_num_reg;
    logic signed [15:0] offset_reg [NUM_AXES];
    logic [5:0]         axis_map_reg;
    logic [2:0]         sign_map_reg;

    // Sequencer state.
    logic [2:0]  state_reg,  state_next;
    logic [1:0]  ax_reg,     ax_next;
    logic [2:0]  step_reg,   step_next;
    logic [1:0]  pause_reg,  pause_next;
    logic [15:0] gain_reg    [NUM_AXES];
    logic [15:0] gain_next   [NUM_AXES];
    logic signed [15:0] field_reg  [NUM_AXES];
    logic signed [15:0] field_next [NUM_AXES];

    // Per-word flags of the result being built.
    logic [2:0]  action_reg, action_next;
    logic        valid_reg,  valid_next;
    logic        rej_reg,    rej_next;
    logic        cfail_reg,  cfail_next;
    logic        ok_reg,     ok_next;

    // Captured input word.
    logic               cmd_reg;
    logic               bus_ok_reg;
    logic               xfer_ok_reg;
    logic signed [15:0] raw_reg [NUM_AXES];

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_load;

    logic        accept;
    logic [2:0]  step_inc;
    logic        div_start;
    div_res_t    div_res;
    logic signed [15:0] cal_raw;
    logic        cal_ok;
    logic [1:0]  sel;
    scale_op_t   scale_op;
    logic signed [15:0] scale_field;
    logic        scale_ok;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_max_reg <= 15'd1000;
            field_min_reg <= 15'd400;
            gain_num_reg  <= 32'd11468800;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
            axis_map_reg  <= 6'd36;
            sign_map_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIELD_MAX: field_max_reg <= cfg_data[14:0];
                CFG_FIELD_MIN: field_min_reg <= cfg_data[14:0];
                CFG_GAIN_NUM:  gain_num_reg  <= cfg_data;
                CFG_OFFSET_X:  offset_reg[0] <= $signed(cfg_data[15:0]);
                CFG_OFFSET_Y:  offset_reg[1] <= $signed(cfg_data[15:0]);
                CFG_OFFSET_Z:  offset_reg[2] <= $signed(cfg_data[15:0]);
                CFG_AXIS_MAP:  axis_map_reg  <= cfg_data[5:0];
                CFG_SIGN_MAP:  sign_map_reg  <= cfg_data[2:0];
            endcase
        end
    end

    // Input capture; the word stays put while the sequencer works on it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= s_axis_tuser[0];
            bus_ok_reg  <= s_axis_tdata[0];
            xfer_ok_reg <= s_axis_tdata[1];
            raw_reg[0]  <= $signed(s_axis_tdata[17:2]);
            raw_reg[1]  <= $signed(s_axis_tdata[33:18]);
            raw_reg[2]  <= $signed(s_axis_tdata[49:34]);
        end
    end

    // Calibration: the divider always runs, and the range check picks its quotient
    // or unity gain when it finishes.
    assign cal_raw   = raw_reg[ax_reg];
    assign cal_ok    = (cal_raw > $signed({1'b0, field_min_reg}))
                    && (cal_raw < $signed({1'b0, field_max_reg}))
                    && (cal_raw > 16'sd0);
    assign div_start = (state_reg == S_DIV_GO);

    mcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (gain_num_reg),
        .den   (cal_raw[14:0]),
        .res   (div_res)
    );

    // Data read: operands of the current body axis feed the shared scaling unit.
    // They stay stable from S_MUL_A through S_MUL_C, when the result is taken.
    assign sel = axis_map_reg[{ax_reg, 1'b0} +: 2];

    always_comb
    begin
        case (sel)
            AXIS_SEL_NONE:
            begin
                scale_op.raw  = '0;
                scale_op.gain = '0;
            end
            default:
            begin
                scale_op.raw  = raw_reg[sel];
                scale_op.gain = gain_reg[sel];
            end
        endcase
        scale_op.negate = sign_map_reg[ax_reg];
        scale_op.offset = offset_reg[ax_reg];
    end

    mcs_scale u_scale (
        .clk       (clk),
        .op        (scale_op),
        .field_max (field_max_reg),
        .field     (scale_field),
        .in_range  (scale_ok)
    );

    assign step_inc = (step_reg < STEP_DATA) ? 3'(step_reg + 3'd1) : STEP_DATA;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        ax_next     = ax_reg;
        step_next   = step_reg;
        pause_next  = pause_reg;
        action_next = action_reg;
        valid_next  = valid_reg;
        rej_next    = rej_reg;
        cfail_next  = cfail_reg;
        ok_next     = ok_reg;
        out_load    = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            gain_next[i]  = gain_reg[i];
            field_next[i] = field_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = ACT_NONE;
                    valid_next  = 1'b0;
                    rej_next    = 1'b0;
                    cfail_next  = 1'b0;
                    ok_next     = 1'b1;
                    ax_next     = '0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_TICK)
                begin
                    if (!bus_ok_reg)
                    begin
                        // A bus fault restarts the sequence; a pending pause is kept.
                        step_next   = STEP_START;
                        action_next = ACT_BUS_RESET;
                    end
                    else if (pause_reg == '0)
                    begin
                        step_next = step_inc;
                        case (step_inc)
                            STEP_IDLE_WR:  action_next = ACT_WRITE_IDLE;
                            STEP_SELFTEST:
                            begin
                                action_next = ACT_WRITE_SELFTEST;
                                pause_next  = SELFTEST_PAUSE;
                            end
                            STEP_CONT_WR:  action_next = ACT_WRITE_CONT;
                            default:       action_next = ACT_READ;
                        endcase
                    end
                    else
                    begin
                        pause_next = 2'(pause_reg - 2'd1);
                    end
                end
                else if (xfer_ok_reg && step_reg == STEP_DATA)
                begin
                    state_next = S_MUL_A;
                end
                else if (xfer_ok_reg && step_reg == STEP_CALIB)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    if (cal_ok)
                    begin
                        gain_next[ax_reg] = div_res.quot;
                    end
                    else
                    begin
                        gain_next[ax_reg] = UNITY_GAIN;
                        cfail_next        = 1'b1;
                        step_next         = STEP_START;
                    end
                    if (ax_reg == LAST_AXIS)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ax_next    = 2'(ax_reg + 2'd1);
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                field_next[ax_reg] = scale_field;
                ok_next            = ok_reg && scale_ok;
                if (ax_reg == LAST_AXIS)
                begin
                    if (ok_reg && scale_ok)
                    begin
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        rej_next  = 1'b1;
                        step_next = STEP_START;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    ax_next    = 2'(ax_reg + 2'd1);
                    state_next = S_MUL_A;
                end
            end
            S_OUT:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= '0;
            step_reg      <= STEP_START;
            pause_reg     <= '0;
            action_reg    <= ACT_NONE;
            valid_reg     <= 1'b0;
            rej_reg       <= 1'b0;
            cfail_reg     <= 1'b0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gain_reg[i]  <= UNITY_GAIN;
                field_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            step_reg      <= step_next;
            pause_reg     <= pause_next;
            action_reg    <= action_next;
            valid_reg     <= valid_next;
            rej_reg       <= rej_next;
            cfail_reg     <= cfail_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gain_reg[i]  <= gain_next[i];
                field_reg[i] <= field_next[i];
            end
        end
    end

    // The result word carries the state as it stands once this word is done.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}},
                             gain_reg[2], gain_reg[1], gain_reg[0],
                             cfail_reg, rej_reg, valid_reg,
                             field_reg[2], field_reg[1], field_reg[0],
                             step_reg, action_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[sim/tb_magnetometer_calib_sequencer.sv]
// Self-checking testbench of the magnetometer calibration sequencer.
`default_nettype none

module tb_magnetometer_calib_sequencer;

    import mcs_pkg::*;

    // One sensor event as it travels on the slave side. The bit order of the packed
    // struct below cmd matches the tdata layout, bus_ok in bit 0.
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] raw2;
        logic signed [15:0] raw1;
        logic signed [15:0] raw0;
        logic               transfer_ok;
        logic               bus_ok;
    } sensor_word_t;

    // One status word as it travels on the master side, action in bit 0.
    typedef struct packed {
        logic [15:0]        gain_z;
        logic [15:0]        gain_y;
        logic [15:0]        gain_x;
        logic               calib_failed;
        logic               reading_rejected;
        logic               field_valid;
        logic signed [15:0] field_z;
        logic signed [15:0] field_y;
        logic signed [15:0] field_x;
        logic [2:0]         step;
        logic [2:0]         action;
    } status_word_t;

    // A row of the start-up table. Where pinned is set, the action and step of the
    // status word are taken from the row itself rather than from the predictor.
    typedef struct packed {
        sensor_word_t word;
        logic         pinned;
        logic [2:0]   act;
        logic [2:0]   stp;
    } startup_row_t;

    // One full set of calibration registers.
    typedef struct packed {
        logic [14:0]        fmax;
        logic [14:0]        fmin;
        logic [31:0]        gnum;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [5:0]         amap;
        logic [2:0]         smap;
    } cal_setting_t;

    localparam int STARTUP_ROWS    = 24;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 150;
    localparam int MAX_REPORTS     = 10;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: the sequence step, the self-test pause, the gains per raw word
    // and the last compensated field, plus a copy of the calibration registers.
    logic [2:0]         step_now;
    logic [1:0]         pause_left;
    logic [15:0]        gain_now [3];
    logic signed [15:0] field_now [3];
    cal_setting_t       cfg_now;

    status_word_t status_q [$];
    startup_row_t startup [STARTUP_ROWS];

    int mismatches     = 0;
    int result_count   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    magnetometer_calib_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Works out the status word that one accepted sensor event causes, and moves the
    // predictor state along with it.
    function automatic status_word_t predict_status(input sensor_word_t w);
        status_word_t       r;
        logic signed [15:0] raws [3];
        logic signed [15:0] offs [3];
        logic [1:0]         sel;
        logic [31:0]        quot;
        longint             scaled;
        int                 mag;
        logic               in_range;
        r = '0;
        raws[0] = w.raw0;
        raws[1] = w.raw1;
        raws[2] = w.raw2;
        offs[0] = cfg_now.ox;
        offs[1] = cfg_now.oy;
        offs[2] = cfg_now.oz;
        if (w.cmd == CMD_TICK)
        begin
            if (!w.bus_ok)
            begin
                // A bus fault restarts the sequence but leaves any pause running.
                step_now = STEP_START;
                r.action = ACT_BUS_RESET;
            end
            else if (pause_left == 2'd0)
            begin
                if (step_now != STEP_DATA)
                    step_now = step_now + 3'd1;
                case (step_now)
                    STEP_IDLE_WR:  r.action = ACT_WRITE_IDLE;
                    STEP_SELFTEST:
                    begin
                        r.action = ACT_WRITE_SELFTEST;
                        pause_left = SELFTEST_PAUSE;
                    end
                    STEP_CONT_WR:  r.action = ACT_WRITE_CONT;
                    default:       r.action = ACT_READ;
                endcase
            end
            else
            begin
                pause_left = pause_left - 2'd1;
            end
        end
        else if (w.transfer_ok)
        begin
            if (step_now == STEP_DATA)
            begin
                in_range = 1'b1;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    sel = cfg_now.amap[2*i +: 2];
                    scaled = 0;
                    if (sel != AXIS_SEL_NONE)
                        scaled = (longint'(raws[sel]) * longint'(gain_now[sel]))
                                 >>> GAIN_FRAC_BITS;
                    if (cfg_now.smap[i])
                        scaled = -scaled;
                    scaled = scaled - (longint'(offs[i]) >>> 1);
                    field_now[i] = scaled[15:0];
                    // The true magnitude is used, so the most negative value never passes.
                    mag = (field_now[i] < 0) ? -int'(field_now[i]) : int'(field_now[i]);
                    if (mag >= int'(cfg_now.fmax))
                        in_range = 1'b0;
                end
                if (in_range)
                begin
                    r.field_valid = 1'b1;
                end
                else
                begin
                    r.reading_rejected = 1'b1;
                    step_now = STEP_START;
                end
            end
            else if (step_now == STEP_CALIB)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (int'(raws[i]) > int'(cfg_now.fmin) && int'(raws[i]) < int'(cfg_now.fmax)
                        && raws[i] > 0)
                    begin
                        quot = cfg_now.gnum / 32'(raws[i]);
                        gain_now[i] = (quot > 32'd65535) ? GAIN_SAT : quot[15:0];
                    end
                    else
                    begin
                        gain_now[i] = UNITY_GAIN;
                        r.calib_failed = 1'b1;
                        step_now = STEP_START;
                    end
                end
            end
        end
        r.step = step_now;
        r.field_x = field_now[0];
        r.field_y = field_now[1];
        r.field_z = field_now[2];
        r.gain_x = gain_now[0];
        r.gain_y = gain_now[1];
        r.gain_z = gain_now[2];
        return r;
    endfunction

    function automatic startup_row_t mk_row(input logic cmd, input logic bus_ok,
                                            input logic tr_ok, input logic signed [15:0] r0,
                                            input logic signed [15:0] r1,
                                            input logic signed [15:0] r2,
                                            input logic pinned, input logic [2:0] act,
                                            input logic [2:0] stp);
        startup_row_t row;
        row.word = '{cmd, r2, r1, r0, tr_ok, bus_ok};
        row.pinned = pinned;
        row.act = act;
        row.stp = stp;
        return row;
    endfunction

    // Random sensor event. Most events follow the sequence: ticks until the
    // calibration step, a calibration read there, and data reads once running.
    // A few bus faults, failed transfers and stray reads are mixed in.
    function automatic sensor_word_t pick_word();
        sensor_word_t       w;
        logic signed [15:0] vals [3];
        int                 roll;
        int                 lo;
        int                 hi;
        int                 span;
        int                 v;
        w = '{CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'b1};
        vals[0] = w.raw0;
        vals[1] = w.raw1;
        vals[2] = w.raw2;
        roll = $urandom_range(99);
        lo = int'(cfg_now.fmin) + 1;
        hi = int'(cfg_now.fmax) - 1;
        span = int'(cfg_now.fmax) / 8 + 1;
        if (roll < 4)
        begin
            w.bus_ok = 1'b0;
        end
        else if (roll < 10)
        begin
            w.cmd = CMD_READ;
            w.transfer_ok = 1'($urandom);
        end
        else if (step_now == STEP_CALIB && roll < 70)
        begin
            w.cmd = CMD_READ;
            w.transfer_ok = 1'b1;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 12)
                begin
                    // Values on and just past the edges of the accepted window.
                    case ($urandom_range(3))
                        0:       v = lo - 1;
                        1:       v = hi + 1;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                    vals[i] = 16'(v);
                end
                else if (roll >= 20 && lo <= hi)
                begin
                    vals[i] = 16'($urandom_range(lo, hi));
                end
            end
        end
        else if (step_now == STEP_DATA && roll < 75)
        begin
            w.cmd = CMD_READ;
            w.transfer_ok = 1'b1;
            if ($urandom_range(99) < 80)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                    vals[i] = 16'(int'($urandom_range(2 * span)) - span);
            end
        end
        if (w.cmd == CMD_READ)
            w.bus_ok = 1'($urandom);
        w.raw0 = vals[0];
        w.raw1 = vals[1];
        w.raw2 = vals[2];
        return w;
    endfunction

    // Offers one word on the slave side, with random gaps before it, and queues its
    // predicted status word when the block takes it. Entered and left at a falling edge.
    task automatic offer_word(input sensor_word_t w, input logic pinned,
                              input logic [2:0] act, input logic [2:0] stp);
        status_word_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, w.raw2, w.raw1, w.raw0,
                         w.transfer_ok, w.bus_ok};
        s_axis_tuser <= w.cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = predict_status(w);
        if (pinned)
        begin
            want.action = act;
            want.step = stp;
        end
        status_q.push_back(want);
        @(negedge clk);
    endtask

    // Stops offering and waits until every queued status word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (status_q.size() != 0);
    endtask

    // Writes one register and mirrors it into the predictor's copy.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            CFG_FIELD_MAX: cfg_now.fmax = val[14:0];
            CFG_FIELD_MIN: cfg_now.fmin = val[14:0];
            CFG_GAIN_NUM:  cfg_now.gnum = val;
            CFG_OFFSET_X:  cfg_now.ox = val[15:0];
            CFG_OFFSET_Y:  cfg_now.oy = val[15:0];
            CFG_OFFSET_Z:  cfg_now.oz = val[15:0];
            CFG_AXIS_MAP:  cfg_now.amap = val[5:0];
            default:       cfg_now.smap = val[2:0];
        endcase
    endtask

    function automatic string show_status(input status_word_t s);
        return $sformatf("act=%0d step=%0d field=(%0d,%0d,%0d) ok=%0b rej=%0b cfail=%0b gain=(%0d,%0d,%0d)",
                         s.action, s.step, s.field_x, s.field_y, s.field_z, s.field_valid,
                         s.reading_rejected, s.calib_failed, s.gain_x, s.gain_y, s.gain_z);
    endfunction

    // Receiver: random back-pressure, and on request one long hold-off during which
    // the block fills up and must stall its input.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checker: every status word taken on the master side is compared with the
    // oldest prediction. A word with nothing waiting is a failure too.
    always @(posedge clk)
    begin
        status_word_t got;
        status_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = status_word_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
            result_count = result_count + 1;
            if (status_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("status word %0d arrived with none pending: %s",
                             result_count, show_status(got));
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("status word %0d mismatch", result_count);
                        $display("  expected %s", show_status(want));
                        $display("  actual   %s", show_status(got));
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        cal_setting_t s;
        int           fmax_i;
        int           fmin_i;
        int           mid;

        // Predictor starts from the reset state of the block.
        step_now = STEP_START;
        pause_left = 2'd0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            gain_now[i] = UNITY_GAIN;
            field_now[i] = 16'sd0;
        end
        cfg_now = '{15'd1000, 15'd400, 32'd11468800, 16'sd0, 16'sd0, 16'sd0, 6'd36, 3'd0};

        // Start-up table, run with the reset values of the registers. It walks the
        // whole sequence twice: once with a bus fault in the self-test pause, then
        // through calibration into data reads, ending on a reading at the most
        // negative value, which can never pass the range check.
        startup[0]  = mk_row(CMD_READ, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_NONE, STEP_START);
        startup[1]  = mk_row(CMD_TICK, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_BUS_RESET, STEP_START);
        startup[2]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_READ, 3'd1);
        startup[3]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_WRITE_IDLE, STEP_IDLE_WR);
        startup[4]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_READ, 3'd3);
        // A completed read outside the calibration and data steps changes nothing.
        startup[5]  = mk_row(CMD_READ, 1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 16'shFFFF,
                             1'b1, ACT_NONE, 3'd3);
        startup[6]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_WRITE_SELFTEST, STEP_SELFTEST);
        startup[7]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_NONE, STEP_SELFTEST);
        // Bus fault in the pause: the step restarts, one pause tick is still owed.
        startup[8]  = mk_row(CMD_TICK, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_BUS_RESET, STEP_START);
        startup[9]  = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_NONE, STEP_START);
        startup[10] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[11] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[12] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[13] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[14] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[15] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);
        startup[16] = mk_row(CMD_TICK, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_READ, STEP_CALIB);
        // A failed transfer leaves everything as it was.
        startup[17] = mk_row(CMD_READ, 1'b1, 1'b0, 16'sd700, 16'sd401, 16'sd999,
                             1'b1, ACT_NONE, STEP_CALIB);
        startup[18] = mk_row(CMD_READ, 1'b0, 1'b1, 16'sd700, 16'sd401, 16'sd999,
                             1'b0, ACT_NONE, STEP_START);
        startup[19] = mk_row(CMD_TICK, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_WRITE_CONT, STEP_CONT_WR);
        startup[20] = mk_row(CMD_TICK, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_READ, STEP_DATA);
        // The step saturates in the data state.
        startup[21] = mk_row(CMD_TICK, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                             1'b1, ACT_READ, STEP_DATA);
        startup[22] = mk_row(CMD_READ, 1'b1, 1'b1, 16'sd500, -16'sd500, 16'sd300,
                             1'b0, ACT_NONE, STEP_START);
        startup[23] = mk_row(CMD_READ, 1'b1, 1'b1, 16'sh8000, 16'sd0, 16'sd0,
                             1'b0, ACT_NONE, STEP_START);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < STARTUP_ROWS; i++)
            offer_word(startup[i].word, startup[i].pinned, startup[i].act, startup[i].stp);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Registers only change while the block is idle.
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (p)
                0:
                    // Widest window, saturating gains, extreme offsets, one dead axis.
                    s = '{15'h7FFF, 15'd1, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 16'shFFFF,
                          6'b11_01_10, 3'b101};
                1:
                    // Empty window: every calibration fails, zero numerator.
                    s = '{15'd1, 15'h7FFF, 32'd0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 3'd0};
                default:
                begin
                    fmax_i = $urandom_range(600, 32767);
                    fmin_i = $urandom_range(1, fmax_i / 2);
                    mid = (fmax_i + fmin_i) / 2;
                    s.fmax = 15'(fmax_i);
                    s.fmin = 15'(fmin_i);
                    s.gnum = 32'(mid) * 32'($urandom_range(8192, 40000));
                    s.ox = 16'(int'($urandom_range(fmax_i / 2)) - fmax_i / 4);
                    s.oy = 16'(int'($urandom_range(fmax_i / 2)) - fmax_i / 4);
                    s.oz = 16'(int'($urandom_range(fmax_i / 2)) - fmax_i / 4);
                    s.amap = 6'($urandom);
                    s.smap = 3'($urandom);
                end
            endcase
            write_reg(CFG_FIELD_MAX, 32'(s.fmax));
            write_reg(CFG_FIELD_MIN, 32'(s.fmin));
            write_reg(CFG_GAIN_NUM, s.gnum);
            write_reg(CFG_OFFSET_X, 32'(s.ox));
            write_reg(CFG_OFFSET_Y, 32'(s.oy));
            write_reg(CFG_OFFSET_Z, 32'(s.oz));
            write_reg(CFG_AXIS_MAP, 32'(s.amap));
            write_reg(CFG_SIGN_MAP, 32'(s.smap));
            cfg_we <= 1'b0;

            // Idle pattern of this phase: none, sender only, receiver only, both.
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (p == 2 && n == 10)
                    hold_requests = hold_requests + 1;
                if (p == 1 && n == 25)
                    drain_results();
                offer_word(pick_word(), 1'b0, ACT_NONE, STEP_START);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
